### hw/rtl/tle_pkg.sv
// Shared types and constants for the terminal line editor.
// No dependencies; every other file of the block imports this package.
package tle_pkg;

    localparam int LINE_DEPTH_DEF = 128;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic CMD_RX   = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic REG_MAX_LEN     = 1'b0;
    localparam logic REG_DROP_SPACES = 1'b1;

    localparam logic [6:0] MAX_LEN_RST     = 7'd79;
    localparam logic       DROP_SPACES_RST = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
    } t_in;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [6:0] line_length;
        logic       last;
    } t_out;

    typedef enum logic [1:0] {
        JOB_ECHO,
        JOB_DONE,
        JOB_READ,
        JOB_BS
    } t_job_kind;

    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] data;
        logic [6:0] length;
    } t_job;

endpackage

### hw/rtl/tle_edit.sv
// Line state, line memory and byte decode; produces at most one result job per item.
// Depends on tle_pkg.
module tle_edit
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in        i_item,
    input  logic [6:0] i_max_len,
    input  logic       i_drop_spaces,
    output logic       o_job_valid,
    output t_job       o_job,
    input  logic       i_job_ready
);

    localparam int MEM_DEPTH = (LINE_DEPTH < 128) ? LINE_DEPTH : 128;
    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [7:0]  MEM_DEPTH_W  = 8'(MEM_DEPTH);
    localparam logic [12:0] LINE_DEPTH_W = 13'(LINE_DEPTH);

    logic [7:0] r_mem [MEM_DEPTH];
    logic [7:0] r_rd_data;
    logic       r_rd_hit;
    logic [6:0] r_fill;
    logic [6:0] r_done;
    logic       r_job_valid;
    t_job       r_job;

    logic       accept;
    logic       is_rx;
    logic       do_store;
    logic       do_bs;
    logic       do_cr;
    logic       makes_job;
    logic       rd_hit;
    logic [6:0] n_fill;
    logic [6:0] n_done;
    t_job       n_job;

    assign o_ready = !r_job_valid || i_job_ready;
    assign accept  = i_valid && o_ready;
    assign is_rx   = (i_item.command == CMD_RX);

    always_comb begin
        do_cr    = is_rx && (i_item.rx_byte == CH_CR);
        do_bs    = is_rx && (i_item.rx_byte == CH_BS) && (r_fill != 7'd0);
        do_store = is_rx && (i_item.rx_byte != CH_CR) && (i_item.rx_byte != CH_BS)
                   && (i_item.rx_byte != CH_ESC)
                   && !((i_item.rx_byte == CH_SPACE) && i_drop_spaces)
                   && (r_fill < i_max_len) && ({1'b0, r_fill} < MEM_DEPTH_W);
        makes_job = !is_rx || do_cr || do_bs || do_store;
        rd_hit = (i_item.read_index < r_done)
                 && ({6'd0, i_item.read_index} < LINE_DEPTH_W);

        n_fill = r_fill;
        n_done = r_done;
        if (do_cr) begin
            n_fill = 7'd0;
            n_done = r_fill;
        end else if (do_bs) begin
            n_fill = r_fill - 7'd1;
        end else if (do_store) begin
            n_fill = r_fill + 7'd1;
        end

        n_job.data   = i_item.rx_byte;
        n_job.length = r_fill;
        if (!is_rx) begin
            n_job.kind = JOB_READ;
        end else if (do_cr) begin
            n_job.kind = JOB_DONE;
        end else if (do_bs) begin
            n_job.kind = JOB_BS;
        end else begin
            n_job.kind = JOB_ECHO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 7'd0;
            r_done      <= 7'd0;
            r_job_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_fill <= n_fill;
                r_done <= n_done;
            end
            if (accept) begin
                r_job_valid <= makes_job;
            end else if (i_job_ready) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job     <= n_job;
            r_rd_hit  <= rd_hit;
            r_rd_data <= r_mem[i_item.read_index[AW-1:0]];
        end
        if (accept && do_store) begin
            r_mem[r_fill[AW-1:0]] <= i_item.rx_byte;
        end
    end

    always_comb begin
        o_job = r_job;
        if (r_job.kind == JOB_READ) begin
            o_job.data = r_rd_hit ? r_rd_data : 8'd0;
        end
    end

    assign o_job_valid = r_job_valid;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_fill} <= MEM_DEPTH_W)
        else $error("fill count beyond line memory");

    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_done} <= MEM_DEPTH_W)
        else $error("completed length beyond line memory");

    a_cr_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && do_cr |=> r_fill == 7'd0 && r_done == $past(r_fill))
        else $error("carriage return did not close the line");

    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_valid && !i_job_ready |=> r_job_valid && $stable(r_job))
        else $error("pending job lost");

endmodule

### hw/rtl/tle_emit.sv
// Result sequencer: turns each job into one or three result beats held in
// an output register. Depends on tle_pkg.
module tle_emit
    import tle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_valid,
    input  t_job i_job,
    output logic o_job_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_item
);

    logic       r_valid;
    t_out       r_item;
    logic [1:0] r_beat;

    logic load;
    logic job_end;
    t_out n_item;

    assign load = i_job_valid && (!r_valid || i_ready);

    always_comb begin
        n_item.kind        = KIND_ECHO;
        n_item.data        = i_job.data;
        n_item.line_length = 7'd0;
        n_item.last        = 1'b1;
        job_end            = 1'b1;
        case (i_job.kind)
            JOB_ECHO: begin
            end
            JOB_DONE: begin
                n_item.kind        = KIND_DONE;
                n_item.data        = 8'd0;
                n_item.line_length = i_job.length;
            end
            JOB_READ: begin
                n_item.kind = KIND_READ;
            end
            JOB_BS: begin
                n_item.data = (r_beat == 2'd1) ? CH_SPACE : CH_BS;
                n_item.last = (r_beat == 2'd2);
                job_end     = (r_beat == 2'd2);
            end
            default: begin
            end
        endcase
    end

    assign o_job_ready = load && job_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_beat  <= job_end ? 2'd0 : r_beat + 2'd1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

    a_beat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat != 2'd3)
        else $error("beat counter out of range");

    a_beat_bs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_beat != 2'd0 |-> i_job_valid && i_job.kind == JOB_BS)
        else $error("partial backspace echo without backspace job");

    a_last_ends_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |-> n_item.last == job_end)
        else $error("last flag does not match end of job");

endmodule

### hw/rtl/terminal_line_editor.sv
// Terminal line editor top level: configuration registers, edit stage, result stage.
// A result is registered in the edit stage's job register and then in the output register
// of the result stage. Throughput: one item per cycle unless the result stage stalls; a
// backspace echo occupies the result stage for its backspace, space and backspace beats.
// Reset (synchronous, active low) empties the line and restores max_len 79, drop_spaces 1.
// The line memory is not cleared; only written positions can be read back.
module terminal_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [6:0] r_max_len;
    logic       r_drop_spaces;
    logic       cfg_wr;
    logic       job_valid;
    logic       job_ready;
    t_job       job;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len     <= MAX_LEN_RST;
            r_drop_spaces <= DROP_SPACES_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_MAX_LEN:     r_max_len     <= pwdata[6:0];
                REG_DROP_SPACES: r_drop_spaces <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MAX_LEN:     prdata = {25'd0, r_max_len};
            REG_DROP_SPACES: prdata = {31'd0, r_drop_spaces};
            default:         prdata = 32'd0;
        endcase
    end

    tle_edit #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_edit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_item        (i_item),
        .i_max_len     (r_max_len),
        .i_drop_spaces (r_drop_spaces),
        .o_job_valid   (job_valid),
        .o_job         (job),
        .i_job_ready   (job_ready)
    );

    tle_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (job_ready),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule
